FILE: rtl/tbd_pkg.sv
`default_nettype none

package tbd_pkg;

  localparam int unsigned Rounds    = 32;
  localparam int unsigned KeyWords  = 4;
  localparam int unsigned WordW     = 32;
  localparam int unsigned BlockW    = 2 * WordW;
  localparam int unsigned CfgIdxW   = $clog2(KeyWords);
  localparam int unsigned Latency   = 2 * Rounds;

  localparam logic [WordW-1:0] Delta = 32'h9E37_79B9;

  typedef logic [KeyWords-1:0][WordW-1:0] tbd_key_t;

  // key bytes 41 f5 df 98 c2 05 48 2b 9b 97 af 01 a5 4b 14 d8, little-endian words
  localparam tbd_key_t KeyReset = {32'hD814_4BA5, 32'h01AF_979B, 32'h2B48_05C2, 32'h98DF_F541};

  localparam logic [CfgIdxW-1:0] CfgKey0 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgKey1 = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgKey2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgKey3 = CfgIdxW'(3);

  // running sum seen by round r, counting from the first decryption round
  function automatic logic [WordW-1:0] round_sum(input int unsigned r);
    logic [63:0] prod;
    prod = 64'(Delta) * 64'(Rounds - r);
    return prod[WordW-1:0];
  endfunction

  function automatic logic [WordW-1:0] mix_half(input logic [WordW-1:0] v,
                                                input logic [WordW-1:0] sum,
                                                input logic [WordW-1:0] ka,
                                                input logic [WordW-1:0] kb);
    return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tbd_key_regs.sv
`default_nettype none

module tbd_key_regs
  import tbd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [WordW-1:0]   cfg_wdata_i,
  output tbd_key_t                key_o
);

  tbd_key_t key_q, key_d;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKey0: key_d[0] = cfg_wdata_i;
        CfgKey1: key_d[1] = cfg_wdata_i;
        CfgKey2: key_d[2] = cfg_wdata_i;
        CfgKey3: key_d[3] = cfg_wdata_i;
        default: key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KeyReset;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

`default_nettype wire

FILE: rtl/tbd_round.sv
`default_nettype none

// one decryption round as two registered half-rounds
module tbd_round
  import tbd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tbd_key_t         key_i,
  input  wire logic [WordW-1:0] sum_i,
  input  wire logic             vld_i,
  input  wire logic [WordW-1:0] v0_i,
  input  wire logic [WordW-1:0] v1_i,
  output logic                  vld_o,
  output logic [WordW-1:0]      v0_o,
  output logic [WordW-1:0]      v1_o
);

  logic             vld_a_q, vld_b_q;
  logic [WordW-1:0] v0_a_q, v1_a_q, v1_a_d;
  logic [WordW-1:0] v0_b_q, v1_b_q, v0_b_d;

  assign v1_a_d = v1_i - mix_half(v0_i, sum_i, key_i[2], key_i[3]);
  assign v0_b_d = v0_a_q - mix_half(v1_a_q, sum_i, key_i[0], key_i[1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    v0_a_q <= v0_i;
    v1_a_q <= v1_a_d;
    v0_b_q <= v0_b_d;
    v1_b_q <= v1_a_q;
  end

  assign vld_o = vld_b_q;
  assign v0_o  = v0_b_q;
  assign v1_o  = v1_b_q;

endmodule

`default_nettype wire

FILE: rtl/tea_block_decrypt_core.sv
`default_nettype none

// channel   ports                                      dir  handshake
// block in  start_i, cipher_block_i[63:0]              in   taken when start_i && !busy_o
// block out done_o, plain_block_o[63:0]                out  done_o marks the word, one cycle
// config    cfg_we_i, cfg_idx_i[1:0], cfg_wdata_i[31:0] in  written when cfg_we_i
//
// each word passes through every round of the pipeline, one half-round per stage
// a new word may be taken every cycle; busy_o stays low
// the receiver cannot stall, so the pipeline never holds
// reset clears the valid bits and loads the default key
// keys are read straight from the key registers: change them only when idle

module tea_block_decrypt_core
  import tbd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [BlockW-1:0]  cipher_block_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [BlockW-1:0]       plain_block_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [WordW-1:0]   cfg_wdata_i
);

  tbd_key_t key;

  logic [Rounds:0]            vld;
  logic [Rounds:0][WordW-1:0] v0;
  logic [Rounds:0][WordW-1:0] v1;

  tbd_key_regs u_key_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_o       (key)
  );

  assign busy_o = 1'b0;
  assign vld[0] = start_i && !busy_o;
  assign v0[0]  = cipher_block_i[WordW-1:0];
  assign v1[0]  = cipher_block_i[BlockW-1:WordW];

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    tbd_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key),
      .sum_i  (round_sum(r)),
      .vld_i  (vld[r]),
      .v0_i   (v0[r]),
      .v1_i   (v1[r]),
      .vld_o  (vld[r+1]),
      .v0_o   (v0[r+1]),
      .v1_o   (v1[r+1])
    );
  end

  assign done_o        = vld[Rounds];
  assign plain_block_o = {v1[Rounds], v0[Rounds]};

`ifndef NO_ASSERTIONS
  a_accept_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("accepted word did not come out after the pipeline latency");

  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result strobe without a matching accepted word");

  a_mid_valid_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[Rounds/2] |-> ##(Latency - 2*(Rounds/2)) done_o)
    else $error("word lost inside the pipeline");
`endif

endmodule

`default_nettype wire
